FILE: rtl/dcdc_spur_free_divider_select_assert.svh
// ----------------------------------------------------------------------------
// dcdc_spur_free_divider_select_assert.svh
// assertion macros shared by the divider select block and its divide unit
// ----------------------------------------------------------------------------
`ifndef DCDC_SPUR_FREE_DIVIDER_SELECT_ASSERT_SVH
`define DCDC_SPUR_FREE_DIVIDER_SELECT_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define DCDCSEL_ASSERT_COMB(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define DCDCSEL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/dcdcsel_pkg.sv
// ----------------------------------------------------------------------------
// dcdcsel_pkg
// widths, register indexes, status codes and divide unit interface types
// ----------------------------------------------------------------------------
package dcdcsel_pkg;

   localparam int FREQ_W    = 32;
   localparam int DIVD_W    = FREQ_W + 1;
   localparam int DIDX_W    = 9;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FREQ = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_MIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_MAX  = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NONE      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_WIN   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 2'd3;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [FREQ_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DIVD_W-1:0] quotient;
   } div_sts_type;

   // zero taken as one
   function automatic logic [FREQ_W-1:0] nonzero(input logic [FREQ_W-1:0] v);
      return (v == '0) ? FREQ_W'(1) : v;
   endfunction

endpackage

FILE: rtl/dcdcsel_div.sv
// ----------------------------------------------------------------------------
// dcdcsel_div
// restoring divider, one quotient bit per cycle, divisor must be nonzero
// ----------------------------------------------------------------------------
module dcdcsel_div (
   input  logic                      clock,
   input  logic                      reset,
   input  dcdcsel_pkg::div_req_type  div_req,
   output dcdcsel_pkg::div_sts_type  div_sts
);
   import dcdcsel_pkg::*;
   `include "dcdc_spur_free_divider_select_assert.svh"

   localparam int CNT_W = $clog2(DIVD_W + 1);

   logic [DIVD_W-1:0] acc_ff;
   logic [FREQ_W-1:0] rem_ff;
   logic [FREQ_W-1:0] dvs_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [DIVD_W-1:0] rem_sh;
   logic              ge;
   logic [FREQ_W-1:0] rem_in;

   always_comb begin
      rem_sh = {rem_ff, acc_ff[DIVD_W-1]};
      ge     = rem_sh >= {1'b0, dvs_ff};
      rem_in = ge ? FREQ_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[FREQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // done pulses once, right after the last quotient bit
         done_ff <= busy_ff && !div_req.start && (cnt_ff == CNT_W'(1));
         if (div_req.start) begin
            acc_ff  <= div_req.dividend;
            dvs_ff  <= div_req.divisor;
            rem_ff  <= '0;
            cnt_ff  <= CNT_W'(DIVD_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            acc_ff <= {acc_ff[DIVD_W-2:0], ge};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign div_sts = '{busy: busy_ff, done: done_ff, quotient: acc_ff};

   `DCDCSEL_ASSERT_COMB(a_div_done_idle, done_ff, !busy_ff, "divider done while busy")
   `DCDCSEL_ASSERT_NEXT(a_div_start_busy, div_req.start, busy_ff, "divider not busy after start")
   `DCDCSEL_ASSERT_NEXT(a_div_count_down, busy_ff && !div_req.start,
      cnt_ff == CNT_W'($past(cnt_ff) - 1'b1), "divider step count skipped")

endmodule

FILE: rtl/dcdc_spur_free_divider_select.sv
// ----------------------------------------------------------------------------
// dcdc_spur_free_divider_select
// picks the smallest dc-dc clock divider whose harmonics miss a receive window
// ----------------------------------------------------------------------------
// One item (window low/high edges in Hz) yields one result item. The block first
// forms the divider bounds round(sync_freq / dcdc_freq_max) and
// round(sync_freq / dcdc_freq_min), then walks the dividers from the smallest up,
// dividing sync_freq by each one and stepping harmonics 1 .. HARMONIC_LIMIT-1 of
// the result by repeated addition; a harmonic in the window moves the walk on to
// the next divider, until a divider is clear or the list ends. All divisions go
// through a single 33-step restoring divider; the harmonic walk for a divider
// stops early once a harmonic passes the window top. req_stall stays high from
// acceptance until the result is placed in the output register; the output
// register lets the next item be accepted while a result still waits on
// rsp_stall. Configuration writes are always taken (csr_ready is tied high) and
// must be made only while idle.
// ----------------------------------------------------------------------------
module dcdc_spur_free_divider_select #(
   parameter int MAX_DIVIDERS   = 256,
   parameter int HARMONIC_LIMIT = 50
) (
   input  logic                                clock,
   input  logic                                reset,
   // request items
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dcdcsel_pkg::FREQ_W-1:0]      req_window_low,
   input  logic [dcdcsel_pkg::FREQ_W-1:0]      req_window_high,
   // result items
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dcdcsel_pkg::STATUS_W-1:0]    rsp_status,
   output logic [dcdcsel_pkg::FREQ_W-1:0]      rsp_chosen_divider,
   output logic [dcdcsel_pkg::FREQ_W-1:0]      rsp_switch_freq,
   output logic [dcdcsel_pkg::DIDX_W-1:0]      rsp_divider_index,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dcdcsel_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dcdcsel_pkg::FREQ_W-1:0]      csr_data
);
   import dcdcsel_pkg::*;
   `include "dcdc_spur_free_divider_select_assert.svh"

   localparam int CW = $clog2(MAX_DIVIDERS);      // divider walk position
   localparam int HW = $clog2(HARMONIC_LIMIT);    // harmonic number
   localparam int PW = FREQ_W + HW;               // exact harmonic product

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_HI,
      S_DIV_LO,
      S_RANGE,
      S_FS,
      S_HARM,
      S_OUT
   } state_type;

   // configuration registers
   logic [FREQ_W-1:0] sync_ff;
   logic [FREQ_W-1:0] fmin_ff;
   logic [FREQ_W-1:0] fmax_ff;

   // sequencer and working registers
   state_type         state_ff;
   logic [FREQ_W-1:0] lo_ff;
   logic [FREQ_W-1:0] hi_ff;
   logic [FREQ_W-1:0] dlarge_ff;
   logic [FREQ_W-1:0] dsmall_ff;
   logic [FREQ_W-1:0] d_ff;
   logic [FREQ_W-1:0] fs_ff;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     idx_ff;
   logic [PW-1:0]     p_ff;
   logic [HW-1:0]     h_ff;
   div_req_type       div_req_ff;
   div_sts_type       div_sts;

   // pending result
   logic [STATUS_W-1:0] res_status_ff;
   logic [FREQ_W-1:0]   res_div_ff;
   logic [FREQ_W-1:0]   res_fs_ff;
   logic [DIDX_W-1:0]   res_idx_ff;

   // output register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [FREQ_W-1:0]   rsp_chosen_divider_ff;
   logic [FREQ_W-1:0]   rsp_switch_freq_ff;
   logic [DIDX_W-1:0]   rsp_divider_index_ff;

   logic [FREQ_W-1:0] fmin_nz;
   logic [FREQ_W-1:0] fmax_nz;
   logic [FREQ_W-1:0] q_nz;
   logic [FREQ_W-1:0] diff;
   logic              range_bad;
   logic              win_bad;
   logic              p_hit;
   logic              p_above;
   logic              last_h;
   logic              last_d;
   logic              div_start_in;

   dcdcsel_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_sts (div_sts)
   );

   always_comb begin
      fmin_nz   = nonzero(fmin_ff);
      fmax_nz   = nonzero(fmax_ff);
      // rounded divider of zero is taken as one, covers the r < f case too
      q_nz      = nonzero(div_sts.quotient[FREQ_W-1:0]);
      diff      = dlarge_ff - dsmall_ff;
      range_bad = (dlarge_ff < dsmall_ff) || (diff >= FREQ_W'(MAX_DIVIDERS - 1));
      win_bad   = lo_ff >= hi_ff;
      p_hit     = (p_ff >= PW'(lo_ff)) && (p_ff <= PW'(hi_ff));
      // harmonics only grow, nothing further can hit once past the top edge
      p_above   = p_ff > PW'(hi_ff);
      last_h    = h_ff == HW'(HARMONIC_LIMIT - 1);
      last_d    = (idx_ff + CW'(1)) == count_ff;
      // sequencer steps that issue a new division
      div_start_in = ((state_ff == S_IDLE) && req_valid) ||
                     ((state_ff == S_DIV_HI) && div_sts.done) ||
                     ((state_ff == S_RANGE) && !range_bad && !win_bad) ||
                     ((state_ff == S_HARM) && p_hit && !last_d);
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= FREQ_W'(50000000);
         fmin_ff <= FREQ_W'(400000);
         fmax_ff <= FREQ_W'(1200000);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SYNC_FREQ: sync_ff <= csr_data;
            CSR_FREQ_MIN:  fmin_ff <= csr_data;
            CSR_FREQ_MAX:  fmax_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         div_req_ff.start <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         div_req_ff.start <= div_start_in;
         // a taken result frees the output register unless a new one loads now
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  lo_ff               <= req_window_low;
                  hi_ff               <= req_window_high;
                  // large bound: sync over the low frequency limit, rounded
                  div_req_ff.dividend <= {1'b0, sync_ff} + DIVD_W'(fmin_nz >> 1);
                  div_req_ff.divisor  <= fmin_nz;
                  state_ff            <= S_DIV_HI;
               end
            end
            S_DIV_HI: begin
               if (div_sts.done) begin
                  dlarge_ff           <= q_nz;
                  div_req_ff.dividend <= {1'b0, sync_ff} + DIVD_W'(fmax_nz >> 1);
                  div_req_ff.divisor  <= fmax_nz;
                  state_ff            <= S_DIV_LO;
               end
            end
            S_DIV_LO: begin
               if (div_sts.done) begin
                  dsmall_ff <= q_nz;
                  state_ff  <= S_RANGE;
               end
            end
            S_RANGE: begin
               res_div_ff <= '0;
               res_fs_ff  <= '0;
               res_idx_ff <= '0;
               if (range_bad) begin
                  res_status_ff <= ST_BAD_RANGE;
                  state_ff      <= S_OUT;
               end else if (win_bad) begin
                  res_status_ff <= ST_BAD_WIN;
                  state_ff      <= S_OUT;
               end else begin
                  count_ff            <= CW'(diff + 1'b1);
                  idx_ff              <= '0;
                  d_ff                <= dsmall_ff;
                  div_req_ff.dividend <= {1'b0, sync_ff};
                  div_req_ff.divisor  <= dsmall_ff;
                  state_ff            <= S_FS;
               end
            end
            S_FS: begin
               if (div_sts.done) begin
                  fs_ff    <= div_sts.quotient[FREQ_W-1:0];
                  p_ff     <= PW'(div_sts.quotient[FREQ_W-1:0]);
                  h_ff     <= HW'(1);
                  state_ff <= S_HARM;
               end
            end
            S_HARM: begin
               if (p_hit) begin
                  // this divider puts a harmonic in the window, try the next one or, after the last, report none
                  if (last_d) begin
                     res_status_ff <= ST_NONE;
                     res_div_ff    <= '0;
                     res_fs_ff     <= '0;
                     res_idx_ff    <= DIDX_W'(count_ff);
                     state_ff      <= S_OUT;
                  end else begin
                     idx_ff              <= idx_ff + 1'b1;
                     d_ff                <= d_ff + 1'b1;
                     div_req_ff.dividend <= {1'b0, sync_ff};
                     div_req_ff.divisor  <= d_ff + 1'b1;
                     state_ff            <= S_FS;
                  end
               end else if (last_h || p_above) begin
                  res_status_ff <= ST_FOUND;
                  res_div_ff    <= d_ff;
                  res_fs_ff     <= fs_ff;
                  res_idx_ff    <= DIDX_W'(idx_ff);
                  state_ff      <= S_OUT;
               end else begin
                  p_ff <= p_ff + PW'(fs_ff);
                  h_ff <= h_ff + 1'b1;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff          <= 1'b1;
                  rsp_status_ff         <= res_status_ff;
                  rsp_chosen_divider_ff <= res_div_ff;
                  rsp_switch_freq_ff    <= res_fs_ff;
                  rsp_divider_index_ff  <= res_idx_ff;
                  state_ff              <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_chosen_divider = rsp_chosen_divider_ff;
   assign rsp_switch_freq    = rsp_switch_freq_ff;
   assign rsp_divider_index  = rsp_divider_index_ff;

   `DCDCSEL_ASSERT_COMB(a_div_start_idle, div_req_ff.start, !div_sts.busy,
      "division started while divider busy")
   `DCDCSEL_ASSERT_COMB(a_found_nonzero, rsp_valid_ff && rsp_status_ff == ST_FOUND,
      rsp_chosen_divider_ff != '0, "found result with zero divider")
   `DCDCSEL_ASSERT_COMB(a_fail_zero, rsp_valid_ff && rsp_status_ff != ST_FOUND,
      rsp_chosen_divider_ff == '0 && rsp_switch_freq_ff == '0,
      "failed result carries divider or frequency")
   `DCDCSEL_ASSERT_NEXT(a_harm_step,
      state_ff == S_HARM && !p_hit && !last_h && !p_above,
      state_ff == S_HARM && h_ff == HW'($past(h_ff) + 1'b1), "harmonic step lost")

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the spur-free dc-dc divider select block
// ----------------------------------------------------------------------------
// Window items go from a queue into a clocked driver. A clocked monitor takes
// result items and compares every field with a prediction. The prediction is
// made when the item is accepted, from the bench's own copy of the three
// frequency registers. The registers are rewritten only while the block is
// drained. The run covers the reset settings, a narrow divider range with
// random windows and one long result hold-off, the extreme register values,
// both kinds of bad divider range, the largest legal divider list, and two
// random register settings.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dcdcsel_pkg::*;

   localparam int          CLK_PERIOD    = 10;
   localparam int          MAX_DIVS      = 256;
   localparam int          HARM_LIMIT    = 50;
   localparam int          SETTLE_CYCLES = 200;
   localparam int          HOLD_AT       = 20;
   localparam int          HOLD_CYCLES   = 3000;
   localparam int unsigned CYCLE_LIMIT   = 1_500_000;

   typedef logic [63:0] wide_type;

   typedef struct packed {
      logic [FREQ_W-1:0] low;
      logic [FREQ_W-1:0] high;
   } window_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FREQ_W-1:0]   divider;
      logic [FREQ_W-1:0]   freq;
      logic [DIDX_W-1:0]   index;
   } choice_type;

   // clock, reset and block ports, the bench-driven ones known from time zero
   logic                 clock              = 1'b0;
   logic                 reset              = 1'b1;
   logic                 req_valid          = 1'b0;
   logic                 req_stall;
   logic [FREQ_W-1:0]    req_window_low     = '0;
   logic [FREQ_W-1:0]    req_window_high    = '0;
   logic                 rsp_valid;
   logic                 rsp_stall          = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [FREQ_W-1:0]    rsp_chosen_divider;
   logic [FREQ_W-1:0]    rsp_switch_freq;
   logic [DIDX_W-1:0]    rsp_divider_index;
   logic                 csr_valid          = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index          = '0;
   logic [FREQ_W-1:0]    csr_data           = '0;

   // bench copy of the frequency registers, starting from their reset values
   logic [FREQ_W-1:0] sync_hz = 32'd50_000_000;
   logic [FREQ_W-1:0] fmin_hz = 32'd400_000;
   logic [FREQ_W-1:0] fmax_hz = 32'd1_200_000;

   window_type windows_to_send[$];
   choice_type choices_due[$];

   // percent chance of a gap or a stall; zero gives a stretch with no idling
   int unsigned idle_pct     = 30;
   int unsigned gap_left     = 0;
   int unsigned stall_left   = 0;
   int unsigned hold_left    = 0;
   bit          hold_done    = 1'b0;
   int unsigned results_seen = 0;
   int unsigned error_count  = 0;
   int unsigned cycles_run   = 0;
   window_type  launch;
   choice_type  due;

   dcdc_spur_free_divider_select #(
      .MAX_DIVIDERS   (MAX_DIVS),
      .HARMONIC_LIMIT (HARM_LIMIT)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_window_low     (req_window_low),
      .req_window_high    (req_window_high),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_chosen_divider (rsp_chosen_divider),
      .rsp_switch_freq    (rsp_switch_freq),
      .rsp_divider_index  (rsp_divider_index),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------------

   // rounded division as the bounds use it: zero divisor and zero result become one
   function automatic wide_type round_ratio(wide_type num, wide_type den);
      wide_type q;
      if (den == 0) den = 1;
      if (num < den) q = 1;
      else q = (num + den / 2) / den;
      if (q == 0) q = 1;
      return q;
   endfunction

   // first divider whose harmonics 1 .. HARM_LIMIT-1 all miss the closed window;
   // products are kept at 64 bits so they never wrap
   function automatic choice_type pick_divider(logic [FREQ_W-1:0] lo,
                                               logic [FREQ_W-1:0] hi);
      choice_type c;
      wide_type   d_lo, d_hi, span, i, h, fs, prod;
      bit         clear;
      c    = '0;
      d_lo = round_ratio(sync_hz, fmax_hz);
      d_hi = round_ratio(sync_hz, fmin_hz);
      // range is judged before the window
      if (d_hi < d_lo || d_hi - d_lo + 1 >= MAX_DIVS) begin
         c.status = ST_BAD_RANGE;
         return c;
      end
      if (lo >= hi) begin
         c.status = ST_BAD_WIN;
         return c;
      end
      span = d_hi - d_lo + 1;
      for (i = 0; i < span; i++) begin
         fs    = wide_type'(sync_hz) / (d_lo + i);
         clear = 1'b1;
         for (h = 1; h < HARM_LIMIT; h++) begin
            prod = fs * h;
            if (prod >= lo && prod <= hi) clear = 1'b0;
         end
         if (clear) begin
            c.status  = ST_FOUND;
            c.divider = FREQ_W'(d_lo + i);
            c.freq    = FREQ_W'(fs);
            c.index   = DIDX_W'(i);
            return c;
         end
      end
      c.status = ST_NONE;
      c.index  = DIDX_W'(span);
      return c;
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   // mostly short idles, a few long ones
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 20);
      return $urandom_range(30, 150);
   endfunction

   // windows aimed at a harmonic of some divider in the current list, so the walk
   // has to skip dividers; the rest is plain noise, empty and top-edge windows
   function automatic window_type random_window();
      window_type  w;
      wide_type    d_lo, d_hi, fs, center, reach, lo64, hi64;
      int unsigned pick;
      d_lo = round_ratio(sync_hz, fmax_hz);
      d_hi = round_ratio(sync_hz, fmin_hz);
      if (d_hi < d_lo) d_hi = d_lo;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         fs     = wide_type'(sync_hz) / $urandom_range(32'(d_lo), 32'(d_hi));
         center = fs * $urandom_range(1, HARM_LIMIT - 1);
         case ($urandom_range(0, 3))
            0:       reach = $urandom_range(0, 300);
            1:       reach = fs / 4;
            2:       reach = fs * 2;
            default: reach = fs * $urandom_range(3, 20);
         endcase
         lo64   = (center > reach) ? center - reach : '0;
         hi64   = center + reach + $urandom_range(0, 3);
         w.low  = (lo64 > 64'hFFFF_FFFF) ? '1 : lo64[FREQ_W-1:0];
         w.high = (hi64 > 64'hFFFF_FFFF) ? '1 : hi64[FREQ_W-1:0];
      end else if (pick < 72) begin
         w.low  = $urandom;
         w.high = $urandom;
      end else if (pick < 86) begin
         w.low  = $urandom_range(0, 1000);
         w.high = $urandom;
      end else if (pick < 93) begin
         // empty window
         w.low  = $urandom;
         w.high = w.low;
      end else begin
         w.low  = $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);
         w.high = '1;
      end
      return w;
   endfunction

   task automatic queue_window(logic [FREQ_W-1:0] lo, logic [FREQ_W-1:0] hi);
      window_type w;
      w.low  = lo;
      w.high = hi;
      windows_to_send.push_back(w);
   endtask

   task automatic queue_random(int unsigned n);
      repeat (n) windows_to_send.push_back(random_window());
   endtask

   // wait until every item is sent and every result is back, then let it settle
   task automatic drain();
      do @(negedge clock);
      while (windows_to_send.size() != 0 || req_valid || choices_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [FREQ_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SYNC_FREQ: sync_hz = value;
         CSR_FREQ_MIN:  fmin_hz = value;
         CSR_FREQ_MAX:  fmax_hz = value;
         default: ;
      endcase
   endtask

   // registers change only with the block empty
   task automatic set_limits(logic [FREQ_W-1:0] sync, logic [FREQ_W-1:0] fmin,
                             logic [FREQ_W-1:0] fmax);
      drain();
      write_reg(CSR_SYNC_FREQ, sync);
      write_reg(CSR_FREQ_MIN, fmin);
      write_reg(CSR_FREQ_MAX, fmax);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // driver: one item at a time from the queue, random gaps after each
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         // prediction is made with the registers in force at acceptance
         if (req_valid && !req_stall)
            choices_due.push_back(pick_divider(req_window_low, req_window_high));
         // a stalled item stays on the port unchanged
         if (!(req_valid && req_stall)) begin
            if (gap_left != 0) begin
               req_valid <= 1'b0;
               gap_left  <= gap_left - 1;
            end else if (windows_to_send.size() != 0) begin
               launch          = windows_to_send.pop_front();
               req_valid       <= 1'b1;
               req_window_low  <= launch.low;
               req_window_high <= launch.high;
               gap_left        <= ($urandom_range(0, 99) < idle_pct) ? idle_len() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: checks each result item and drives the result stall
   // ---------------------------------------------------------------------------
   task automatic check_field(string name, logic [FREQ_W-1:0] want, logic [FREQ_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         error_count = error_count + 1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (choices_due.size() == 0) begin
               $display("%0t: result item with none expected, got status %0d divider %0d",
                        $time, rsp_status, rsp_chosen_divider);
               error_count = error_count + 1;
            end else begin
               due = choices_due.pop_front();
               check_field("status", due.status, rsp_status);
               check_field("chosen_divider", due.divider, rsp_chosen_divider);
               check_field("switch_freq", due.freq, rsp_switch_freq);
               check_field("divider_index", due.index, rsp_divider_index);
            end
         end
         // one long hold-off while the sender keeps offering, so the block backs up
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (!hold_done && results_seen == HOLD_AT) begin
            rsp_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end else if (stall_left != 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            rsp_stall  <= 1'b1;
            stall_left <= idle_len() - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog
   // ---------------------------------------------------------------------------
   initial begin
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------
   initial begin
      logic [FREQ_W-1:0] rnd_sync, rnd_fmax;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: dividers 42 .. 125, top switching frequency 50e6 / 42
      queue_window(32'd0, 32'hFFFF_FFFF);                  // every divider hit at h=1
      queue_window(32'hFFFF_FFFE, 32'hFFFF_FFFF);          // top of the range, clear
      queue_window(32'd0, 32'd1);                          // bottom of the range
      queue_window(32'd7, 32'd7);                          // empty window
      queue_window(32'hFFFF_FFFF, 32'd0);                  // reversed window
      queue_window(32'd50_000_000 / 42, 32'd50_000_000 / 42 + 1);   // first fundamental
      queue_window(32'd49 * (32'd50_000_000 / 42) - 3,
                   32'd49 * (32'd50_000_000 / 42));         // last harmonic on upper edge
      queue_window(32'd50 * (32'd50_000_000 / 42),
                   32'd50 * (32'd50_000_000 / 42) + 10);    // first harmonic not counted
      queue_window(32'd400_000, 32'd1_200_000);            // whole band of fundamentals
      queue_window(32'd1_000_000, 32'd30_000_000);         // partial overlap

      // narrow list (dividers 10 .. 25) with random windows; long hold-off lands here
      set_limits(32'd50_000_000, 32'd2_000_000, 32'd5_000_000);
      idle_pct = 35;
      queue_random(55);

      // extremes, no idling on either side
      set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      idle_pct = 0;
      queue_window(32'hFFFF_FFFE, 32'hFFFF_FFFF);   // fundamental inside
      queue_window(32'd0, 32'hFFFF_FFFE);           // second harmonic only past 32 bits
      queue_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // empty window at the top

      // zero min and max taken as one: single divider 100, switching at 1 Hz
      set_limits(32'd100, 32'd0, 32'd0);
      queue_window(32'd50, 32'd60);                 // just above the last harmonic
      queue_window(32'd49, 32'd60);                 // last harmonic on lower edge
      queue_window(32'd0, 32'd1);

      // zero sync: divider 1, switching frequency zero
      set_limits(32'd0, 32'd400_000, 32'd1_200_000);
      queue_window(32'd0, 32'd5);
      queue_window(32'd1, 32'd5);

      // min above max gives a reversed divider list; bad range wins over bad window
      set_limits(32'd50_000_000, 32'd2_000_000, 32'd1_000_000);
      idle_pct = 20;
      queue_window(32'd0, 32'd10);
      queue_window(32'd9, 32'd9);

      // 256 dividers is one too many
      set_limits(32'd2_560, 32'd10, 32'd2_560);
      queue_window(32'd0, 32'd100);

      // 255 dividers, the longest legal walk
      set_limits(32'd2_550, 32'd10, 32'd2_550);
      queue_window(32'd0, 32'd2_550);
      queue_window(32'd2_551, 32'd2_600);
      queue_random(2);

      // half-way rounding of the bounds: 25 / 10 goes up to 3
      set_limits(32'd25, 32'd10, 32'd25);
      queue_random(3);

      // two random register settings with short divider lists
      repeat (2) begin
         rnd_sync = $urandom_range(1_000_000, 200_000_000);
         rnd_fmax = rnd_sync / $urandom_range(1, 20);
         set_limits(rnd_sync, rnd_fmax / $urandom_range(1, 4), rnd_fmax);
         idle_pct = $urandom_range(10, 40);
         queue_random(8);
      end

      drain();
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
